// ----- hdl/mcd_pkg.sv -----
// Package for the milestone crossing detector.
// Holds payload structs, widths, control structs and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package mcd_pkg;

	localparam int MAX_GROUP_ATOMS = 4096;
	localparam int POS_W = 24;
	localparam int CNT_W = $clog2(MAX_GROUP_ATOMS + 1);
	localparam int SUM_W = POS_W + CNT_W;
	localparam int DIV_BITS = SUM_W;
	localparam int CENT_W = POS_W + 1;
	localparam int DELTA_W = CENT_W + 1;
	localparam int MAG_W = POS_W + 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int DIST_W = 52;
	localparam int RAD_W = 24;
	localparam int RSQ_W = 2 * RAD_W;
	localparam int NUM_AXES = 3;
	localparam int NUM_SUMS = 2 * NUM_AXES;

	localparam logic [1:0] REG_INNER = 2'd0;
	localparam logic [1:0] REG_MIDDLE = 2'd1;
	localparam logic [1:0] REG_OUTER = 2'd2;

	localparam logic [1:0] CODE_INNER = 2'd1;
	localparam logic [1:0] CODE_MIDDLE = 2'd2;
	localparam logic [1:0] CODE_OUTER = 2'd3;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic                    group_select;
		logic                    frame_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        crossing_code;
		logic [DIST_W-1:0] distance_sq;
		logic              empty_group;
	} out_item_t;

	typedef struct packed {
		logic       acc;
		logic       div_load;
		logic       div_step;
		logic       div_store;
		logic       sq_en;
		logic       class_load;
		logic       empty_load;
		logic [2:0] idx;
		logic [1:0] axis;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
	} dp_status_t;

endpackage

// ----- hdl/mcd_datapath.sv -----
// Datapath of the milestone crossing detector: sums, counts, shared divider,
// squaring, radius registers, classification and output register.
// Depends on mcd_pkg.
`timescale 1ns / 1ps

module mcd_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  mcd_pkg::in_item_t  in_data,
	input  mcd_pkg::dp_cmd_t   cmd,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output mcd_pkg::dp_status_t status,
	output mcd_pkg::out_item_t out_data
);
	import mcd_pkg::*;

	logic signed [SUM_W-1:0]  sums_q [NUM_SUMS];
	logic [CNT_W-1:0]         counts_q [2];
	logic [RAD_W-1:0]         rad_q [NUM_AXES];
	logic [RSQ_W-1:0]         rsq_q [NUM_AXES];
	logic [SUM_W-1:0]         dvd_q;
	logic [CNT_W-1:0]         rem_q;
	logic [CNT_W-1:0]         divisor_q;
	logic                     neg_q;
	logic signed [CENT_W-1:0] cent_q [NUM_SUMS];
	logic [PROD_W-1:0]        prod_q;
	logic [DIST_W-1:0]        dist_q;
	logic [DIST_W-1:0]        prev_q;
	logic                     prev_valid_q;
	logic [1:0]               code_q;
	out_item_t                out_q;

	logic signed [SUM_W-1:0]  sel_sum;
	logic [CNT_W-1:0]         sel_cnt;
	logic [SUM_W-1:0]         sel_mag;
	logic [CNT_W:0]           trial;
	logic                     qbit;
	logic [CENT_W-1:0]        qmag;
	logic signed [DELTA_W-1:0] delta;
	logic [MAG_W-1:0]         dmag;
	logic [DIST_W-1:0]        r1;
	logic [DIST_W-1:0]        r2;
	logic [DIST_W-1:0]        r3;
	logic                     mid;
	logic [1:0]               new_code;
	logic                     g;
	logic [2:0]               base;

	assign g = in_data.group_select;
	assign base = g ? 3'(NUM_AXES) : 3'd0;
	assign status.empty = (counts_q[0] == '0) || (counts_q[1] == '0);
	assign out_data = out_q;

	assign sel_sum = sums_q[cmd.idx];
	assign sel_cnt = counts_q[cmd.idx >= 3'(NUM_AXES)];
	assign sel_mag = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);

	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign qbit = (trial >= {1'b0, divisor_q});
	assign qmag = {1'b0, dvd_q[CENT_W-2:0]};

	assign delta = DELTA_W'(cent_q[NUM_AXES]) - DELTA_W'(cent_q[0]);
	assign dmag = delta[DELTA_W-1] ? MAG_W'(-delta) : MAG_W'(delta);

	assign r1 = DIST_W'(rsq_q[0]);
	assign r2 = DIST_W'(rsq_q[1]);
	assign r3 = DIST_W'(rsq_q[2]);
	assign mid = prev_valid_q && (((dist_q < r2) && (prev_q > r2)) ||
		((dist_q > r2) && (prev_q < r2)));

	always_comb begin
		if (dist_q < r1) begin
			new_code = CODE_INNER;
		end else if (mid) begin
			new_code = CODE_MIDDLE;
		end else if (dist_q > r3) begin
			new_code = CODE_OUTER;
		end else begin
			new_code = code_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SUMS; i++) begin
				sums_q[i] <= '0;
			end
			counts_q[0] <= '0;
			counts_q[1] <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				rad_q[i] <= '0;
			end
			prev_q <= '0;
			prev_valid_q <= 1'b0;
			code_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INNER:  rad_q[0] <= cfg_data;
					REG_MIDDLE: rad_q[1] <= cfg_data;
					REG_OUTER:  rad_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.acc && counts_q[g] < CNT_W'(MAX_GROUP_ATOMS)) begin
				sums_q[base] <= sums_q[base] + SUM_W'(in_data.pos_x);
				sums_q[base + 3'd1] <= sums_q[base + 3'd1] + SUM_W'(in_data.pos_y);
				sums_q[base + 3'd2] <= sums_q[base + 3'd2] + SUM_W'(in_data.pos_z);
				counts_q[g] <= counts_q[g] + 1'b1;
			end
			if (cmd.class_load) begin
				code_q <= new_code;
				prev_q <= dist_q;
				prev_valid_q <= 1'b1;
			end
			if (cmd.class_load || cmd.empty_load) begin
				for (int i = 0; i < NUM_SUMS; i++) begin
					sums_q[i] <= '0;
				end
				counts_q[0] <= '0;
				counts_q[1] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_q <= sel_mag + SUM_W'(sel_cnt >> 1);
			divisor_q <= sel_cnt;
			neg_q <= sel_sum[SUM_W-1];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? CNT_W'(trial - {1'b0, divisor_q}) : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], qbit};
		end
		if (cmd.div_store) begin
			for (int i = 0; i < NUM_SUMS - 1; i++) begin
				cent_q[i] <= cent_q[i+1];
			end
			cent_q[NUM_SUMS-1] <= neg_q ? CENT_W'(-qmag) : CENT_W'(qmag);
		end
		if (cmd.sq_en) begin
			if (cmd.axis == 2'd0) begin
				dist_q <= '0;
			end else begin
				dist_q <= dist_q + DIST_W'(prod_q);
			end
			if (cmd.axis != 2'd3) begin
				prod_q <= dmag * dmag;
				rsq_q[cmd.axis] <= rad_q[cmd.axis] * rad_q[cmd.axis];
				for (int i = 0; i < NUM_SUMS - 1; i++) begin
					cent_q[i] <= cent_q[i+1];
				end
				cent_q[NUM_SUMS-1] <= cent_q[0];
			end
		end
		if (cmd.class_load) begin
			out_q.crossing_code <= new_code;
			out_q.distance_sq <= dist_q;
			out_q.empty_group <= 1'b0;
		end else if (cmd.empty_load) begin
			out_q.crossing_code <= code_q;
			out_q.distance_sq <= '0;
			out_q.empty_group <= 1'b1;
		end
	end

endmodule

// ----- hdl/mcd_ctrl.sv -----
// Controller of the milestone crossing detector: sequences accumulation,
// division, squaring and classification, and owns the handshakes.
// Depends on mcd_pkg.
`timescale 1ns / 1ps

module mcd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                frame_end,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  mcd_pkg::dp_status_t status,
	output mcd_pkg::dp_cmd_t    cmd
);
	import mcd_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DLOAD = 3'd2;
	localparam logic [2:0] S_DRUN = 3'd3;
	localparam logic [2:0] S_DSTORE = 3'd4;
	localparam logic [2:0] S_SQ = 3'd5;
	localparam logic [2:0] S_CLASS = 3'd6;
	localparam logic [2:0] S_EMPTY = 3'd7;

	localparam int BIT_W = $clog2(DIV_BITS + 1);

	logic [2:0]       state_q;
	logic [2:0]       idx_q;
	logic [BIT_W-1:0] bit_q;
	logic [1:0]       axis_q;
	logic             out_valid_q;
	logic             out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		cmd.axis = axis_q;
		case (state_q)
			S_IDLE:   cmd.acc = in_valid;
			S_DLOAD:  cmd.div_load = 1'b1;
			S_DRUN:   cmd.div_step = 1'b1;
			S_DSTORE: cmd.div_store = 1'b1;
			S_SQ:     cmd.sq_en = 1'b1;
			S_CLASS:  cmd.class_load = out_free;
			S_EMPTY:  cmd.empty_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			bit_q <= '0;
			axis_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q inside {S_CLASS, S_EMPTY}) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && frame_end) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					idx_q <= '0;
					state_q <= status.empty ? S_EMPTY : S_DLOAD;
				end
				S_DLOAD: begin
					bit_q <= '0;
					state_q <= S_DRUN;
				end
				S_DRUN: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == BIT_W'(DIV_BITS - 1)) begin
						state_q <= S_DSTORE;
					end
				end
				S_DSTORE: begin
					if (idx_q == 3'(NUM_SUMS - 1)) begin
						axis_q <= '0;
						state_q <= S_SQ;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_DLOAD;
					end
				end
				S_SQ: begin
					axis_q <= axis_q + 1'b1;
					if (axis_q == 2'd3) begin
						state_q <= S_CLASS;
					end
				end
				S_CLASS, S_EMPTY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/milestone_crossing_detector.sv -----
// Milestone crossing detector, top level.
// Input channel: one atom position per transaction (in_valid / in_stall),
//   tagged with its group; frame_end marks the last atom of a frame.
// Output channel: one result per frame (out_valid / out_stall): crossing
//   code, squared centroid distance and an empty-group flag.
// Configuration: cfg_we writes cfg_data into radius register cfg_index
//   (0 inner, 1 middle, 2 outer); write only while the block is idle.
// Evaluation: a non-final atom is taken without stalling the input. A
//   frame_end atom holds the input while six centroid divisions run on
//   one shared restoring divider (37 quotient bits each), then squaring
//   and classification. An empty group skips the divisions and squaring.
// Latency: the result appears the cycle after classification.
// Stall: a result waits in the output register while the next frame's atoms
//   are accepted; the following frame_end result waits for it to clear.
// Reset: sums, counts, previous distance, crossing code and radii clear.
// Depends on mcd_pkg, mcd_ctrl and mcd_datapath.
`timescale 1ns / 1ps

module milestone_crossing_detector (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mcd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mcd_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import mcd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	mcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.frame_end (in_data.frame_end),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mcd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.frame_end |=> in_stall)
		else $error("frame end transaction did not start evaluation");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.empty_group |-> out_data.distance_sq == '0)
		else $error("empty group result carries a distance");

	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an evaluation");

	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.acc, cmd.div_load, cmd.div_step, cmd.div_store,
			cmd.sq_en, cmd.class_load, cmd.empty_load}))
		else $error("datapath commands overlap");
`endif

endmodule

// ----- test/mcd_checker.sv -----
// Checker for the milestone crossing detector: watches both channels,
// predicts each frame result from accepted atoms and compares field by field.
// Depends on mcd_pkg.
`timescale 1ns / 1ps

module mcd_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  mcd_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  mcd_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output int                 fail_count,
	output int                 pending_count
);
	import mcd_pkg::*;

	logic [23:0] rad_inner, rad_middle, rad_outer;
	longint      sums [6];
	int          counts [2];
	logic [51:0] last_dist;
	logic        last_valid;
	logic [1:0]  code_state;
	out_item_t   expected_results [$];

	assign pending_count = expected_results.size();

	function automatic longint centroid(longint s, int n);
		longint mag;
		longint q;
		mag = (s < 0) ? -s : s;
		q = (mag + n / 2) / n;
		return (s < 0) ? -q : q;
	endfunction

	task automatic absorb_atom(in_item_t it);
		int g;
		longint delta;
		logic [63:0] d, r1, r2, r3;
		logic mid;
		out_item_t r;
		g = it.group_select;
		if (counts[g] < MAX_GROUP_ATOMS) begin
			sums[g*3]   += longint'(it.pos_x);
			sums[g*3+1] += longint'(it.pos_y);
			sums[g*3+2] += longint'(it.pos_z);
			counts[g]++;
		end
		if (!it.frame_end)
			return;
		if (counts[0] == 0 || counts[1] == 0) begin
			r.crossing_code = code_state;
			r.distance_sq = '0;
			r.empty_group = 1'b1;
		end else begin
			d = 0;
			for (int k = 0; k < 3; k++) begin
				delta = centroid(sums[3+k], counts[1]) - centroid(sums[k], counts[0]);
				if (delta < 0)
					delta = -delta;
				d += 64'(delta) * 64'(delta);
			end
			d &= 64'hF_FFFF_FFFF_FFFF;
			r1 = 64'(rad_inner) * 64'(rad_inner);
			r2 = 64'(rad_middle) * 64'(rad_middle);
			r3 = 64'(rad_outer) * 64'(rad_outer);
			mid = last_valid && ((d < r2 && 64'(last_dist) > r2) ||
				(d > r2 && 64'(last_dist) < r2));
			if (d < r1)
				code_state = CODE_INNER;
			else if (mid)
				code_state = CODE_MIDDLE;
			else if (d > r3)
				code_state = CODE_OUTER;
			last_dist = d[51:0];
			last_valid = 1'b1;
			r.crossing_code = code_state;
			r.distance_sq = d[51:0];
			r.empty_group = 1'b0;
		end
		expected_results.insert(expected_results.size(), r);
		foreach (sums[i])
			sums[i] = 0;
		counts[0] = 0;
		counts[1] = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			rad_inner = 0;
			rad_middle = 0;
			rad_outer = 0;
			foreach (sums[i])
				sums[i] = 0;
			counts[0] = 0;
			counts[1] = 0;
			last_dist = 0;
			last_valid = 0;
			code_state = 0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INNER: rad_inner = cfg_data;
					REG_MIDDLE: rad_middle = cfg_data;
					REG_OUTER: rad_outer = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %p", out_data);
				end else begin
					e = expected_results.pop_front();
					if (out_data.crossing_code !== e.crossing_code ||
						out_data.distance_sq !== e.distance_sq ||
						out_data.empty_group !== e.empty_group) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp %0d %0h %0b, got %0d %0h %0b",
								e.crossing_code, e.distance_sq, e.empty_group,
								out_data.crossing_code, out_data.distance_sq,
								out_data.empty_group);
					end
				end
			end
			if (in_valid && !in_stall)
				absorb_atom(in_data);
		end
	end
endmodule

// ----- test/tb_milestone_crossing_detector.sv -----
// Testbench top for the milestone crossing detector: drives atom frames,
// radius writes and random stalls; gives the verdict from mcd_checker.
// Depends on mcd_pkg, mcd_checker and the block.
`timescale 1ns / 1ps

module tb_milestone_crossing_detector;
	import mcd_pkg::*;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 0;
	out_item_t out_data;
	logic      cfg_we = 0;
	logic [1:0] cfg_index = REG_INNER;
	logic [23:0] cfg_data = 0;
	int        fail_count, pending_count;
	int        send_idle = 0, recv_idle = 0;
	int        quiet_cycles = 0;
	logic      done = 0;

	always #2 clk = ~clk;

	milestone_crossing_detector u_top (.*);

	mcd_checker u_chk (.*);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		if (quiet_cycles > 20000 && !done) begin
			$display("tb_milestone_crossing_detector failed");
			$finish;
		end
	end

	task automatic send_atom(logic [23:0] x, logic [23:0] y, logic [23:0] z,
		logic g, logic fe);
		in_item_t it;
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		it.group_select = g;
		it.frame_end = fe;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic go_idle();
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_radius(logic [1:0] idx, logic [23:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic set_radii(logic [23:0] a, logic [23:0] b, logic [23:0] c);
		go_idle();
		write_radius(REG_INNER, a);
		write_radius(REG_MIDDLE, b);
		write_radius(REG_OUTER, c);
		cfg_we <= 0;
	endtask

	function automatic logic [23:0] rand_pos(int spread);
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			default: return 24'($signed($urandom_range(2 * spread)) - spread);
		endcase
	endfunction

	task automatic random_frame(int spread);
		int n;
		n = $urandom_range(12, 1);
		for (int i = 0; i < n; i++)
			send_atom(rand_pos(spread), rand_pos(spread), rand_pos(spread),
				1'($urandom_range(1)), (i == n - 1));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty groups, extremes, first frame
		send_atom(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b1);
		send_atom(24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b1);
		send_atom(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0);
		send_atom(24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b1);
		send_atom(24'h000003, 24'hFFFFFD, 24'h0, 1'b0, 1'b0);
		send_atom(24'h000000, 24'h0, 24'h0, 1'b0, 1'b0);
		send_atom(24'hFFFFFF, 24'h000001, 24'h0, 1'b1, 1'b0);
		send_atom(24'h0, 24'h0, 24'h0, 1'b1, 1'b1);
		set_radii(24'h010000, 24'h020000, 24'h040000);
		send_atom(24'h0, 24'h0, 24'h0, 1'b0, 1'b0);
		send_atom(24'h008000, 24'h0, 24'h0, 1'b1, 1'b1);
		send_atom(24'h0, 24'h0, 24'h0, 1'b0, 1'b0);
		send_atom(24'h030000, 24'h0, 24'h0, 1'b1, 1'b1);
		send_atom(24'h0, 24'h0, 24'h0, 1'b0, 1'b0);
		send_atom(24'h050000, 24'h0, 24'h0, 1'b1, 1'b1);
		send_atom(24'h0, 24'h0, 24'h0, 1'b0, 1'b0);
		send_atom(24'h010000, 24'h0, 24'h0, 1'b1, 1'b1);
		send_atom(24'h0, 24'h0, 24'h0, 1'b0, 1'b0);
		send_atom(24'h020000, 24'h0, 24'h0, 1'b1, 1'b1);
		set_radii(24'hFFFFFF, 24'h0, 24'h0);
		send_atom(24'h0, 24'h0, 24'h0, 1'b0, 1'b0);
		send_atom(24'h7FFFFF, 24'h0, 24'h0, 1'b1, 1'b1);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 9 : (phase == 1) ? 72 : 0;
			recv_idle = (phase == 0) ? 72 : (phase == 1) ? 9 : 0;
			case (phase)
				0: set_radii(24'h0, 24'h0, 24'h0);
				1: set_radii(24'h040000, 24'h080000, 24'h100000);
				default: set_radii(24'($urandom), 24'($urandom), 24'($urandom));
			endcase
			for (int f = 0; f < 43; f++) begin
				random_frame((phase == 1) ? 24'h0C0000 : 24'h7FFFFF);
				if (f == 20)
					set_radii(24'($urandom_range(24'h080000)),
						24'($urandom_range(24'h100000)),
						24'($urandom_range(24'h200000)));
			end
		end

		recv_idle = 0;
		go_idle();
		done = 1;
		if (fail_count == 0)
			$display("tb_milestone_crossing_detector passed");
		else
			$display("tb_milestone_crossing_detector failed");
		$finish;
	end
endmodule
